### rtl/core/affine_matrix_inverse_top_assert.svh
// ----------------------------------------------------------------------------
// affine matrix inverse assertion macros
// concurrent checks clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_TOP_ASSERT_SVH

// condition holds in the same cycle
`define AMI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define AMI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ami_pkg.sv
// ----------------------------------------------------------------------------
// ami_pkg
// shared types and constants of the affine matrix inverse block
// ----------------------------------------------------------------------------
package ami_pkg;

   localparam int DATA_WIDTH = 32;

   localparam logic [1:0] FIRST_ROW = 2'd0;
   localparam logic [1:0] LAST_ROW  = 2'd2;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type a00;
      word_type a01;
      word_type a02;
      word_type a03;
      word_type a10;
      word_type a11;
      word_type a12;
      word_type a13;
      word_type a20;
      word_type a21;
      word_type a22;
      word_type a23;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      word_type   c0;
      word_type   c1;
      word_type   c2;
      word_type   c3;
      logic       singular;
      logic       last_row;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] row;
   } tag_type;

endpackage

### rtl/core/ami_row_issue.sv
// ----------------------------------------------------------------------------
// ami_row_issue
// holds one matrix and issues its three result rows into the pipeline
// ----------------------------------------------------------------------------
module ami_row_issue (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             req_valid,
   output logic             req_ready,
   input  ami_pkg::req_type req_data,
   output ami_pkg::tag_type tag,
   output ami_pkg::req_type item
);
   import ami_pkg::*;

   logic       hold_ff;
   logic [1:0] row_ff;
   req_type    item_ff;
   logic       take;

   assign req_ready = !hold_ff || (adv && row_ff == LAST_ROW);
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         row_ff  <= FIRST_ROW;
      end else if (take) begin
         hold_ff <= 1'b1;
         row_ff  <= FIRST_ROW;
      end else if (adv && hold_ff) begin
         if (row_ff == LAST_ROW) begin
            hold_ff <= 1'b0;
         end else begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   assign tag  = '{valid: hold_ff, row: row_ff};
   assign item = item_ff;

endmodule

### rtl/core/ami_cofactor.sv
// ----------------------------------------------------------------------------
// ami_cofactor
// five stage datapath: adjugate row, determinant and adjugate times translation
// ----------------------------------------------------------------------------
module ami_cofactor (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  ami_pkg::tag_type                         in_tag,
   input  ami_pkg::req_type                         item,
   output ami_pkg::tag_type                         out_tag,
   output logic signed [2*ami_pkg::DATA_WIDTH:0]    adj [3],
   output logic signed [3*ami_pkg::DATA_WIDTH+2:0]  s_sum,
   output logic signed [3*ami_pkg::DATA_WIDTH+2:0]  det
);
   import ami_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int AW = 2*W + 1;
   localparam int TW = 3*W + 1;
   localparam int SW = 3*W + 3;

   word_type   m [3][3];
   word_type   t [3];
   logic [1:0] c1;
   logic [1:0] c2;

   tag_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;

   logic signed [2*W-1:0] ap_ff [3];
   logic signed [2*W-1:0] aq_ff [3];
   logic signed [2*W-1:0] dp_ff [3];
   logic signed [2*W-1:0] dq_ff [3];
   word_type              m0_1_ff [3];
   word_type              t_1_ff [3];

   logic signed [AW-1:0]  adj2_ff [3];
   logic signed [AW-1:0]  dcf2_ff [3];
   word_type              m0_2_ff [3];
   word_type              t_2_ff [3];

   logic signed [2*W:0]   dlo_ff [3];
   logic signed [2*W:0]   dhi_ff [3];
   logic signed [2*W:0]   slo_ff [3];
   logic signed [2*W:0]   shi_ff [3];
   logic signed [AW-1:0]  adj3_ff [3];

   logic signed [TW-1:0]  dt4_ff [3];
   logic signed [TW-1:0]  st4_ff [3];
   logic signed [AW-1:0]  adj4_ff [3];

   logic signed [SW-1:0]  det5_ff;
   logic signed [SW-1:0]  s5_ff;
   logic signed [AW-1:0]  adj5_ff [3];

   always_comb begin
      m[0][0] = item.a00;
      m[0][1] = item.a01;
      m[0][2] = item.a02;
      m[1][0] = item.a10;
      m[1][1] = item.a11;
      m[1][2] = item.a12;
      m[2][0] = item.a20;
      m[2][1] = item.a21;
      m[2][2] = item.a22;
      t[0]    = item.a03;
      t[1]    = item.a13;
      t[2]    = item.a23;
   end

   // column rotation picks the cofactors of this row
   always_comb begin
      case (in_tag.row)
         FIRST_ROW: begin
            c1 = 2'd1;
            c2 = 2'd2;
         end
         LAST_ROW: begin
            c1 = 2'd0;
            c2 = 2'd1;
         end
         default: begin
            c1 = 2'd2;
            c2 = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
         t4_ff <= '0;
         t5_ff <= '0;
      end else if (adv) begin
         t1_ff <= in_tag;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         t4_ff <= t3_ff;
         t5_ff <= t4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            ap_ff[j]   <= m[(j+1)%3][c1] * m[(j+2)%3][c2];
            aq_ff[j]   <= m[(j+1)%3][c2] * m[(j+2)%3][c1];
            dp_ff[j]   <= m[1][(j+1)%3] * m[2][(j+2)%3];
            dq_ff[j]   <= m[1][(j+2)%3] * m[2][(j+1)%3];
            m0_1_ff[j] <= m[0][j];
            t_1_ff[j]  <= t[j];

            adj2_ff[j] <= AW'(ap_ff[j]) - AW'(aq_ff[j]);
            dcf2_ff[j] <= AW'(dp_ff[j]) - AW'(dq_ff[j]);
            m0_2_ff[j] <= m0_1_ff[j];
            t_2_ff[j]  <= t_1_ff[j];

            // split the wide factor into a low unsigned and a high signed part
            dlo_ff[j]  <= m0_2_ff[j] * $signed({1'b0, dcf2_ff[j][W-1:0]});
            dhi_ff[j]  <= m0_2_ff[j] * $signed(dcf2_ff[j][AW-1:W]);
            slo_ff[j]  <= t_2_ff[j] * $signed({1'b0, adj2_ff[j][W-1:0]});
            shi_ff[j]  <= t_2_ff[j] * $signed(adj2_ff[j][AW-1:W]);
            adj3_ff[j] <= adj2_ff[j];

            dt4_ff[j]  <= (TW'(dhi_ff[j]) <<< W) + TW'(dlo_ff[j]);
            st4_ff[j]  <= (TW'(shi_ff[j]) <<< W) + TW'(slo_ff[j]);
            adj4_ff[j] <= adj3_ff[j];

            adj5_ff[j] <= adj4_ff[j];
         end
         det5_ff <= SW'(dt4_ff[0]) + SW'(dt4_ff[1]) + SW'(dt4_ff[2]);
         s5_ff   <= SW'(st4_ff[0]) + SW'(st4_ff[1]) + SW'(st4_ff[2]);
      end
   end

   assign out_tag = t5_ff;
   assign adj     = adj5_ff;
   assign s_sum   = s5_ff;
   assign det     = det5_ff;

endmodule

### rtl/core/ami_divide.sv
// ----------------------------------------------------------------------------
// ami_divide
// four lane pipelined restoring divider, one quotient bit per stage,
// round to nearest with ties away from zero and saturation
// ----------------------------------------------------------------------------
module ami_divide #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  ami_pkg::tag_type                         in_tag,
   input  logic signed [2*ami_pkg::DATA_WIDTH:0]    adj [3],
   input  logic signed [3*ami_pkg::DATA_WIDTH+2:0]  s_sum,
   input  logic signed [3*ami_pkg::DATA_WIDTH+2:0]  det,
   output ami_pkg::tag_type                         out_tag,
   output ami_pkg::word_type                        entry [4],
   output logic                                     singular
);
   import ami_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int AW  = 2*W + 1;
   localparam int SW  = 3*W + 3;
   localparam int QW  = W + 1;
   localparam int NWA = AW + 2*FRAC_BITS;
   localparam int NWS = SW + FRAC_BITS;
   localparam int NW  = (NWA > NWS) ? NWA : NWS;
   localparam int CW  = (NW > SW + QW) ? NW : SW + QW;

   logic [AW-1:0] adj_abs [3];
   logic [SW-1:0] s_abs;
   logic [SW-1:0] den_abs;

   tag_type       tag0_ff;
   logic [CW-1:0] mag0_ff [4];
   logic [CW-1:0] den0_ff;
   logic [3:0]    neg0_ff;
   logic          sing0_ff;

   tag_type       tag_ff  [QW+1];
   logic [CW-1:0] rem_ff  [QW+1][4];
   logic [QW-1:0] quo_ff  [QW+1][4];
   logic [CW-1:0] den_ff  [QW+1];
   logic [3:0]    neg_ff  [QW+1];
   logic [3:0]    sat_ff  [QW+1];
   logic          sing_ff [QW+1];

   tag_type       tagr_ff;
   logic [QW:0]   rq_ff [4];
   logic [3:0]    negr_ff;
   logic [3:0]    satr_ff;
   logic          singr_ff;

   logic [QW:0]   lim [4];
   logic [QW:0]   mag [4];
   logic [QW:0]   val [4];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         adj_abs[j] = adj[j][AW-1] ? AW'(-adj[j]) : AW'(adj[j]);
      end
      s_abs   = s_sum[SW-1] ? SW'(-s_sum) : SW'(s_sum);
      den_abs = det[SW-1] ? SW'(-det) : SW'(det);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tagr_ff <= '0;
         for (int n = 0; n <= QW; n++) begin
            tag_ff[n] <= '0;
         end
      end else if (adv) begin
         tag0_ff   <= in_tag;
         tag_ff[0] <= tag0_ff;
         for (int n = 1; n <= QW; n++) begin
            tag_ff[n] <= tag_ff[n-1];
         end
         tagr_ff <= tag_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // magnitudes and result signs
         for (int j = 0; j < 3; j++) begin
            mag0_ff[j] <= CW'(adj_abs[j]) << (2*FRAC_BITS);
            neg0_ff[j] <= adj[j][AW-1] ^ det[SW-1];
         end
         mag0_ff[3] <= CW'(s_abs) << FRAC_BITS;
         neg0_ff[3] <= (!s_sum[SW-1] && s_sum != '0) ^ det[SW-1];
         den0_ff    <= CW'(den_abs);
         sing0_ff   <= (det == '0);

         // quotient too large for the quotient bits
         for (int j = 0; j < 4; j++) begin
            rem_ff[0][j] <= mag0_ff[j];
            quo_ff[0][j] <= '0;
            sat_ff[0][j] <= mag0_ff[j] >= (den0_ff << QW);
         end
         den_ff[0]  <= den0_ff;
         neg_ff[0]  <= neg0_ff;
         sing_ff[0] <= sing0_ff;

         for (int n = 1; n <= QW; n++) begin
            for (int j = 0; j < 4; j++) begin
               if (rem_ff[n-1][j] >= (den_ff[n-1] << (QW-n))) begin
                  rem_ff[n][j] <= rem_ff[n-1][j] - (den_ff[n-1] << (QW-n));
                  quo_ff[n][j] <= quo_ff[n-1][j] | (QW'(1) << (QW-n));
               end else begin
                  rem_ff[n][j] <= rem_ff[n-1][j];
                  quo_ff[n][j] <= quo_ff[n-1][j];
               end
            end
            den_ff[n]  <= den_ff[n-1];
            neg_ff[n]  <= neg_ff[n-1];
            sat_ff[n]  <= sat_ff[n-1];
            sing_ff[n] <= sing_ff[n-1];
         end

         // round half away from zero on the magnitude
         for (int j = 0; j < 4; j++) begin
            rq_ff[j] <= (QW+1)'(quo_ff[QW][j])
                      + (QW+1)'(({1'b0, rem_ff[QW][j]} << 1) >= {1'b0, den_ff[QW]});
         end
         negr_ff  <= neg_ff[QW];
         satr_ff  <= sat_ff[QW];
         singr_ff <= sing_ff[QW];
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         lim[j] = negr_ff[j] ? ((QW+1)'(1) << (W-1)) : (((QW+1)'(1) << (W-1)) - 1'b1);
         mag[j] = (satr_ff[j] || rq_ff[j] > lim[j]) ? lim[j] : rq_ff[j];
         val[j] = negr_ff[j] ? -mag[j] : mag[j];
         entry[j] = singr_ff ? '0 : word_type'(val[j][W-1:0]);
      end
   end

   assign out_tag  = tagr_ff;
   assign singular = singr_ff;

endmodule

### rtl/core/affine_matrix_inverse_top.sv
// ----------------------------------------------------------------------------
// affine_matrix_inverse_top
// inverse of an affine 3x4 matrix in signed fixed point, one row per item out
// ----------------------------------------------------------------------------
// req channel: one item is the top three rows of an affine matrix, twelve
// signed words. rsp channel: three items per matrix, rows 0, 1, 2 in order,
// each with three inverse entries, the inverse translation entry, singular
// and last_row flags.
// a new matrix is taken while the input holding register is empty or
// issuing the last of the three result rows of the one before; the rest
// of the datapath is a single pipeline that takes one row per cycle unless
// rsp_ready stalls it. the restoring divider, one quotient bit per stage,
// sets most of that pipeline's depth.
// reset clears the valid bits of every stage and the output register; no
// clearing pass is needed. while rsp_ready is low with a row waiting, the
// whole pipeline holds and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ami_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ami_pkg::rsp_type rsp_data
);
   import ami_pkg::*;
`include "affine_matrix_inverse_top_assert.svh"

   localparam int W = DATA_WIDTH;

   logic                  adv;
   tag_type               issue_tag;
   req_type               issue_item;
   tag_type               cof_tag;
   logic signed [2*W:0]   cof_adj [3];
   logic signed [3*W+2:0] cof_s;
   logic signed [3*W+2:0] cof_det;
   tag_type               div_tag;
   word_type              div_entry [4];
   logic                  div_sing;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   assign adv = !rsp_valid_ff || rsp_ready;

   ami_row_issue u_issue (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tag       (issue_tag),
      .item      (issue_item)
   );

   ami_cofactor u_cofactor (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (issue_tag),
      .item    (issue_item),
      .out_tag (cof_tag),
      .adj     (cof_adj),
      .s_sum   (cof_s),
      .det     (cof_det)
   );

   ami_divide #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divide (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_tag   (cof_tag),
      .adj      (cof_adj),
      .s_sum    (cof_s),
      .det      (cof_det),
      .out_tag  (div_tag),
      .entry    (div_entry),
      .singular (div_sing)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.row_index <= div_tag.row;
         rsp_data_ff.c0        <= div_entry[0];
         rsp_data_ff.c1        <= div_entry[1];
         rsp_data_ff.c2        <= div_entry[2];
         rsp_data_ff.c3        <= div_entry[3];
         rsp_data_ff.singular  <= div_sing;
         rsp_data_ff.last_row  <= (div_tag.row == LAST_ROW);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `AMI_ASSERT_NEXT(a_take_starts_row0, req_valid && req_ready, issue_tag.valid && issue_tag.row == FIRST_ROW, "accepted item did not start at row 0")
   `AMI_ASSERT_NEXT(a_issue_holds, issue_tag.valid && !adv, issue_tag.valid && $stable(issue_tag.row), "issued row moved during a stall")
   `AMI_ASSERT_NOW(a_no_take_mid_item, issue_tag.valid && issue_tag.row != LAST_ROW, !req_ready, "ready while rows of an item remain")

endmodule

### bench/tb_affine_matrix_inverse_top.sv
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse_top
// self-checking bench for the affine 3x4 matrix inverse
// ----------------------------------------------------------------------------
// matrices are queued by the stimulus process, driven on the falling edge and
// predicted on acceptance with exact wide integer arithmetic, then each row
// that comes out is compared field by field with the oldest expected row.
// four phases vary the sender gaps and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ami_pkg::*;

   localparam int FRAC          = 16;
   localparam int DRAIN_CYCLES  = 80;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int PHASE_ITEMS   = 118;

   typedef logic signed [159:0] wide_type;
   typedef logic [159:0]        mag_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_mats[$];
   rsp_type expected_rows[$];
   logic    req_took;
   int      sender_idle_pct;
   int      receiver_stall_pct;
   int      error_count;
   int      quiet_cycles;

   affine_matrix_inverse_top #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exact quotient, rounded half away from zero, clamped to the word range
   function automatic word_type round_div(wide_type num, wide_type den);
      logic    neg;
      mag_type n;
      mag_type d;
      mag_type q;
      mag_type r;
      mag_type lim;
      begin
         neg = num[159] ^ den[159];
         n = num[159] ? mag_type'(-num) : mag_type'(num);
         d = den[159] ? mag_type'(-den) : mag_type'(den);
         q = n / d;
         r = n - q * d;
         if ((r << 1) >= d) q = q + 1;
         lim = neg ? (mag_type'(1) << 31) : ((mag_type'(1) << 31) - 1);
         if (q > lim) q = lim;
         round_div = neg ? word_type'(-q[31:0]) : word_type'(q[31:0]);
      end
   endfunction

   task automatic predict_inverse(req_type m);
      wide_type a[3][3];
      wide_type t[3];
      wide_type adj[3][3];
      wide_type det;
      wide_type s;
      rsp_type  row;
      begin
         a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02; t[0] = m.a03;
         a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12; t[1] = m.a13;
         a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22; t[2] = m.a23;
         adj[0][0] = a[2][2] * a[1][1] - a[2][1] * a[1][2];
         adj[0][1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
         adj[0][2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
         adj[1][0] = a[2][0] * a[1][2] - a[2][2] * a[1][0];
         adj[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
         adj[1][2] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
         adj[2][0] = a[2][1] * a[1][0] - a[2][0] * a[1][1];
         adj[2][1] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
         adj[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
         det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
         for (int i = 0; i < 3; i++) begin
            row = '0;
            row.row_index = 2'(i);
            row.singular  = (det == 0);
            row.last_row  = (2'(i) == LAST_ROW);
            if (det != 0) begin
               row.c0 = round_div(adj[i][0] <<< (2 * FRAC), det);
               row.c1 = round_div(adj[i][1] <<< (2 * FRAC), det);
               row.c2 = round_div(adj[i][2] <<< (2 * FRAC), det);
               s = adj[i][0] * t[0] + adj[i][1] * t[1] + adj[i][2] * t[2];
               row.c3 = round_div((-s) <<< FRAC, det);
            end
            expected_rows.push_back(row);
         end
      end
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      begin
         $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
         error_count++;
      end
   endtask

   function automatic req_type make_mat(word_type w00, word_type w01, word_type w02,
                                        word_type w03, word_type w10, word_type w11,
                                        word_type w12, word_type w13, word_type w20,
                                        word_type w21, word_type w22, word_type w23);
      req_type m;
      begin
         m.a00 = w00; m.a01 = w01; m.a02 = w02; m.a03 = w03;
         m.a10 = w10; m.a11 = w11; m.a12 = w12; m.a13 = w13;
         m.a20 = w20; m.a21 = w21; m.a22 = w22; m.a23 = w23;
         make_mat = m;
      end
   endfunction

   function automatic word_type small_word();
      small_word = word_type'($urandom_range(0, 2 ** 19)) - word_type'(2 ** 18);
   endfunction

   function automatic req_type random_mat();
      req_type m;
      int      pick;
      begin
         pick = $urandom_range(0, 99);
         m = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
         if (pick < 60) begin
            m.a00 = small_word(); m.a01 = small_word(); m.a02 = small_word();
            m.a10 = small_word(); m.a11 = small_word(); m.a12 = small_word();
            m.a20 = small_word(); m.a21 = small_word(); m.a22 = small_word();
            if ($urandom_range(0, 1)) begin
               m.a03 = small_word(); m.a13 = small_word(); m.a23 = small_word();
            end
         end else if (pick < 75) begin
            // singular: repeated row, negated row or zero column
            case ($urandom_range(0, 2))
               0: begin
                  m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
               end
               1: begin
                  m.a10 = -m.a20; m.a11 = -m.a21; m.a12 = -m.a22;
               end
               default: begin
                  m.a01 = '0; m.a11 = '0; m.a21 = '0;
               end
            endcase
         end
         random_mat = m;
      end
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_mats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_data  <= pending_mats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // monitor, predictor feed and watchdog
   always @(posedge clock) begin
      rsp_type want;
      req_took <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) predict_inverse(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected row_index", 32'(rsp_data.row_index), 32'd0);
         end else begin
            want = expected_rows.pop_front();
            if (rsp_data.row_index !== want.row_index)
               report_mismatch("row_index", 32'(rsp_data.row_index), 32'(want.row_index));
            if (rsp_data.c0 !== want.c0) report_mismatch("c0", rsp_data.c0, want.c0);
            if (rsp_data.c1 !== want.c1) report_mismatch("c1", rsp_data.c1, want.c1);
            if (rsp_data.c2 !== want.c2) report_mismatch("c2", rsp_data.c2, want.c2);
            if (rsp_data.c3 !== want.c3) report_mismatch("c3", rsp_data.c3, want.c3);
            if (rsp_data.singular !== want.singular)
               report_mismatch("singular", 32'(rsp_data.singular), 32'(want.singular));
            if (rsp_data.last_row !== want.last_row)
               report_mismatch("last_row", 32'(rsp_data.last_row), 32'(want.last_row));
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_mats.size() == 0 && expected_rows.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      word_type one;
      word_type wmax;
      word_type wmin;
      one  = word_type'(1 << FRAC);
      wmax = {1'b0, {31{1'b1}}};
      wmin = {1'b1, {31{1'b0}}};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      req_took = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      error_count = 0;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, scaling, rotation, singular, extremes, saturation
      pending_mats.push_back(make_mat(one, 0, 0, 0, 0, one, 0, 0, 0, 0, one, 0));
      pending_mats.push_back(make_mat(2 * one, 0, 0, 3 * one, 0, 4 * one, 0, -one,
                                      0, 0, -8 * one, one / 2));
      pending_mats.push_back(make_mat(0, -one, 0, one, one, 0, 0, 2 * one,
                                      0, 0, one, -5 * one));
      pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_mats.push_back(make_mat(wmax, wmax, wmax, wmax, wmax, wmax, wmax, wmax,
                                      wmax, wmax, wmax, wmax));
      pending_mats.push_back(make_mat(wmin, wmin, wmin, wmin, wmin, wmin, wmin, wmin,
                                      wmin, wmin, wmin, wmin));
      pending_mats.push_back(make_mat(wmin, 0, 0, wmax, 0, wmin, 0, wmin,
                                      0, 0, wmin, wmax));
      pending_mats.push_back(make_mat(wmax, 0, 0, wmin, 0, wmax, 0, wmax,
                                      0, 0, wmax, wmin));
      pending_mats.push_back(make_mat(1, 0, 0, one, 0, 1, 0, 0, 0, 0, 1, -one));
      pending_mats.push_back(make_mat(-1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0));
      pending_mats.push_back(make_mat(one, 0, 0, wmin, 0, one, 0, wmax,
                                      0, 0, one, wmin));
      pending_mats.push_back(make_mat(3, 0, 0, 1, 0, 3, 0, -1, 0, 0, 3, 1));
      pending_mats.push_back(make_mat(2 * one, 0, 0, 1, 0, 2 * one, 0, -1,
                                      0, 0, 2 * one, 3));
      pending_mats.push_back(make_mat(one, 2 * one, 3 * one, 0, 2 * one, 4 * one,
                                      6 * one, 0, 0, one, one, 0));
      pending_mats.push_back(make_mat(one, one, 0, 0, one, -one, 0, 0, 0, 0, 3 * one,
                                      0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) pending_mats.push_back(random_mat());
         while (pending_mats.size() > 0 || expected_rows.size() > 0 || req_valid)
            @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rows.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
